@@ rtl/afa_pkg.sv @@
// ----------------------------------------------------------------------------
// afa_pkg
// Shared constants, types and helpers of the anisotropy field accumulator.
// ----------------------------------------------------------------------------
package afa_pkg;

    localparam int SITE_COUNT = 4096;
    localparam int SITE_W     = 12;
    localparam int SITE_AW    = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
    localparam int DATA_W     = 32;
    localparam int AXIS_W     = 16;
    localparam int FIELD_W    = 48;
    localparam int EPOCH_W    = 8;
    localparam int RAM_W      = 3 * FIELD_W + EPOCH_W;
    localparam int DOT_W      = 50;
    localparam int DA_W       = 48;
    localparam int DEN_W      = 62;
    localparam int NUM_W      = 82;
    localparam int CNT_W      = 7;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [SITE_W-1:0]        site;
        logic signed [DATA_W-1:0] spin_x;
        logic signed [DATA_W-1:0] spin_y;
        logic signed [DATA_W-1:0] spin_z;
        logic signed [DATA_W-1:0] moment;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
        logic signed [DATA_W-1:0] strength;
        logic                     last;
        logic                     in_range;
        logic                     applies;
    } t_item;

    // clip a 49-bit sum to the 48-bit field range
    function automatic logic [FIELD_W:0] sat_field(input logic signed [FIELD_W:0] s);
        logic [FIELD_W:0] r;
        if (s[FIELD_W] != s[FIELD_W-1]) begin
            r = {1'b1, s[FIELD_W], {(FIELD_W-1){~s[FIELD_W]}}};
        end else begin
            r = {1'b0, s[FIELD_W-1:0]};
        end
        return r;
    endfunction

endpackage

@@ rtl/afa_ram.sv @@
// ----------------------------------------------------------------------------
// afa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/afa_front.sv @@
// ----------------------------------------------------------------------------
// afa_front
// Accepts entries, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module afa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [afa_pkg::SITE_W-1:0]    i_site_index,
    input  logic signed [afa_pkg::DATA_W-1:0] i_spin_x,
    input  logic signed [afa_pkg::DATA_W-1:0] i_spin_y,
    input  logic signed [afa_pkg::DATA_W-1:0] i_spin_z,
    input  logic signed [afa_pkg::DATA_W-1:0] i_moment_size,
    input  logic signed [afa_pkg::AXIS_W-1:0] i_axis_x,
    input  logic signed [afa_pkg::AXIS_W-1:0] i_axis_y,
    input  logic signed [afa_pkg::AXIS_W-1:0] i_axis_z,
    input  logic signed [afa_pkg::DATA_W-1:0] i_strength,
    input  logic                          i_last,
    output logic                          o_q_valid,
    output afa_pkg::t_item                o_q_item,
    input  logic                          i_q_pop
);
    import afa_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      in_item;
    logic       push;

    always_comb begin
        in_item.site     = i_site_index;
        in_item.spin_x   = i_spin_x;
        in_item.spin_y   = i_spin_y;
        in_item.spin_z   = i_spin_z;
        in_item.moment   = i_moment_size;
        in_item.axis_x   = i_axis_x;
        in_item.axis_y   = i_axis_y;
        in_item.axis_z   = i_axis_z;
        in_item.strength = i_strength;
        in_item.last     = i_last;
        in_item.in_range = 32'(i_site_index) < 32'(SITE_COUNT);
        in_item.applies  = in_item.in_range && (i_moment_size > 0);
    end

    assign o_stall   = r_cnt[1];
    assign push      = i_valid && !o_stall;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

@@ rtl/afa_back.sv @@
// ----------------------------------------------------------------------------
// afa_back
// Sequencer: dot product, bit-serial divide, scaling and field store update.
// ----------------------------------------------------------------------------
module afa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  afa_pkg::t_item                i_q_item,
    output logic                          o_q_pop,
    input  logic signed [afa_pkg::DATA_W-1:0] i_scale,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [afa_pkg::SITE_W-1:0]    o_out_site,
    output logic signed [afa_pkg::FIELD_W-1:0] o_field_x,
    output logic signed [afa_pkg::FIELD_W-1:0] o_field_y,
    output logic signed [afa_pkg::FIELD_W-1:0] o_field_z,
    output logic                          o_applied,
    output logic                          o_saturated,
    output logic                          o_pass_end
);
    import afa_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_READ, S_DOT, S_DEN, S_NUM0, S_NUM1, S_NUM2,
        S_DIV, S_V, S_P, S_PR, S_CM, S_CA, S_WR, S_OUT
    } t_state;

    t_state                    r_state;
    t_item                     r_item;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [DOT_W-1:0]   r_acc;
    logic [DEN_W-1:0]          r_den;
    logic [DATA_W-1:0]         r_ka;
    logic [DA_W-1:0]           r_da;
    logic                      r_neg;
    logic [55:0]               r_mlo, r_mhi;
    logic [NUM_W-1:0]          r_num;
    logic [DEN_W-1:0]          r_rem;
    logic [DATA_W:0]           r_q;
    logic                      r_qovf;
    logic signed [DATA_W-1:0]  r_v;
    logic signed [63:0]        r_prod;
    logic signed [FIELD_W-1:0] r_p;
    logic signed [FIELD_W-1:0] r_f [3];
    logic                      r_sat;
    logic [EPOCH_W-1:0]        r_epoch;
    logic [SITE_AW-1:0]        r_sw;
    logic                      r_valid;

    logic signed [DATA_W-1:0]  sel_spin;
    logic signed [AXIS_W-1:0]  sel_axis;
    logic signed [47:0]        dot_prod;
    logic [DEN_W:0]            rem_sh;
    logic                      ge;
    logic [RAM_W-1:0]          rd_data;
    logic                      rd_hit;
    logic                      we;
    logic [SITE_AW-1:0]        waddr;
    logic [RAM_W-1:0]          wdata;
    logic signed [FIELD_W-1:0] cval;
    logic [FIELD_W:0]          sum_sat;
    logic [DATA_W:0]           k_ext;
    logic [DOT_W-1:0]          d_abs;

    afa_ram #(.W(RAM_W), .DEPTH(SITE_COUNT), .AW(SITE_AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_q_item.site[SITE_AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin sel_spin = r_item.spin_x; sel_axis = r_item.axis_x; end
            2'd1:    begin sel_spin = r_item.spin_y; sel_axis = r_item.axis_y; end
            default: begin sel_spin = r_item.spin_z; sel_axis = r_item.axis_z; end
        endcase
        dot_prod = sel_spin * sel_axis;
        rem_sh   = {r_rem, r_num[NUM_W-1]};
        ge       = rem_sh >= {1'b0, r_den};
        rd_hit   = rd_data[RAM_W-1 -: EPOCH_W] == r_epoch;
        cval     = FIELD_W'((r_prod + 64'sd16384) >>> 15);
        sum_sat  = sat_field((FIELD_W+1)'(r_f[r_cnt[1:0]]) + (FIELD_W+1)'(cval));
        k_ext    = {r_item.strength[DATA_W-1], r_item.strength};
        d_abs    = r_acc[DOT_W-1] ? DOT_W'(-r_acc) : DOT_W'(r_acc);
        we       = (r_state == S_SWEEP) || (r_state == S_WR);
        waddr    = (r_state == S_SWEEP) ? r_sw : r_item.site[SITE_AW-1:0];
        wdata    = (r_state == S_SWEEP) ? {r_epoch, {(3*FIELD_W){1'b0}}}
                                        : {r_epoch, r_f[2], r_f[1], r_f[0]};
        o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sw    <= '0;
            r_epoch <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_SWEEP: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == SITE_AW'(SITE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_sat <= 1'b0;
                    r_cnt <= '0;
                    r_acc <= '0;
                    if (!r_item.in_range) begin
                        r_f[0] <= '0;
                        r_f[1] <= '0;
                        r_f[2] <= '0;
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else begin
                        r_f[0] <= rd_hit ? rd_data[FIELD_W-1:0] : '0;
                        r_f[1] <= rd_hit ? rd_data[2*FIELD_W-1:FIELD_W] : '0;
                        r_f[2] <= rd_hit ? rd_data[3*FIELD_W-1:2*FIELD_W] : '0;
                        if (!r_item.applies) begin
                            r_state <= S_OUT;
                            r_valid <= 1'b1;
                        end else begin
                            r_state <= S_DOT;
                        end
                    end
                end
                S_DOT: begin
                    r_acc <= r_acc + DOT_W'(dot_prod);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(2)) begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den <= DEN_W'(r_item.moment[DATA_W-2:0])
                           * DEN_W'(r_item.moment[DATA_W-2:0]);
                    r_ka  <= r_item.strength[DATA_W-1] ? DATA_W'(-k_ext) : DATA_W'(k_ext);
                    r_da  <= d_abs[DA_W-1:0];
                    r_neg <= r_item.strength[DATA_W-1] != r_acc[DOT_W-1];
                    r_state <= S_NUM0;
                end
                S_NUM0: begin
                    r_mlo   <= 56'(r_ka) * 56'(r_da[23:0]);
                    r_state <= S_NUM1;
                end
                S_NUM1: begin
                    r_mhi   <= 56'(r_ka) * 56'(r_da[47:24]);
                    r_state <= S_NUM2;
                end
                S_NUM2: begin
                    // numerator is 4*|K|*|D|
                    r_num  <= NUM_W'(((NUM_W'(r_mhi) << 24) + NUM_W'(r_mlo)) << 2);
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_qovf <= 1'b0;
                    r_cnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
                    r_q    <= {r_q[DATA_W-1:0], ge};
                    r_qovf <= r_qovf | r_q[DATA_W];
                    r_num  <= r_num << 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= S_V;
                    end
                end
                S_V: begin
                    if (r_neg) begin
                        if (r_qovf || r_q > {2'b01, {(DATA_W-1){1'b0}}}) begin
                            r_sat <= 1'b1;
                            r_v   <= {1'b1, {(DATA_W-1){1'b0}}};
                        end else begin
                            r_v <= DATA_W'(-r_q);
                        end
                    end else begin
                        if (r_qovf || r_q[DATA_W:DATA_W-1] != 2'b00) begin
                            r_sat <= 1'b1;
                            r_v   <= {1'b0, {(DATA_W-1){1'b1}}};
                        end else begin
                            r_v <= DATA_W'(r_q);
                        end
                    end
                    r_state <= S_P;
                end
                S_P: begin
                    r_prod  <= r_v * i_scale;
                    r_state <= S_PR;
                end
                S_PR: begin
                    r_p     <= FIELD_W'((r_prod + 64'sd32768) >>> 16);
                    r_cnt   <= '0;
                    r_state <= S_CM;
                end
                S_CM: begin
                    r_prod  <= r_p * sel_axis;
                    r_state <= S_CA;
                end
                S_CA: begin
                    r_f[r_cnt[1:0]] <= sum_sat[FIELD_W-1:0];
                    if (sum_sat[FIELD_W]) begin
                        r_sat <= 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    r_state <= (r_cnt == CNT_W'(2)) ? S_WR : S_CM;
                end
                S_WR: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        // new pass: advance the epoch, sweep the store on wrap
                        if (r_item.last && r_epoch == '1) begin
                            r_sw    <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                        if (r_item.last) begin
                            r_epoch <= r_epoch + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_out_site  = r_item.site;
    assign o_field_x   = r_f[0];
    assign o_field_y   = r_f[1];
    assign o_field_z   = r_f[2];
    assign o_applied   = r_item.applies;
    assign o_saturated = r_sat;
    assign o_pass_end  = r_item.last;
endmodule

@@ rtl/anisotropy_field_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// anisotropy_field_accumulator_top
// Per-site uniaxial anisotropy field accumulator with saturating store.
// ----------------------------------------------------------------------------
//  channel | signals                     | direction
//  input   | i_valid / o_stall + fields  | entries in
//  output  | o_valid / i_stall + fields  | site totals out
//  config  | i_cfg_valid / o_cfg_ready   | field_scale write
//
//  An applied entry runs the one-bit-per-cycle 82-step divider; a skipped
//  entry goes from the store read straight to the output.
//  After reset, and whenever the 8-bit pass epoch wraps, the store is swept
//  site by site, and the back takes no entry from the queue meanwhile.
//  The front queue keeps taking up to two entries while the back is busy.
// ----------------------------------------------------------------------------
module anisotropy_field_accumulator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [afa_pkg::SITE_W-1:0]    i_site_index,
    input  logic signed [afa_pkg::DATA_W-1:0] i_spin_x,
    input  logic signed [afa_pkg::DATA_W-1:0] i_spin_y,
    input  logic signed [afa_pkg::DATA_W-1:0] i_spin_z,
    input  logic signed [afa_pkg::DATA_W-1:0] i_moment_size,
    input  logic signed [afa_pkg::AXIS_W-1:0] i_axis_x,
    input  logic signed [afa_pkg::AXIS_W-1:0] i_axis_y,
    input  logic signed [afa_pkg::AXIS_W-1:0] i_axis_z,
    input  logic signed [afa_pkg::DATA_W-1:0] i_strength,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [afa_pkg::SITE_W-1:0]    o_out_site,
    output logic signed [afa_pkg::FIELD_W-1:0] o_field_x,
    output logic signed [afa_pkg::FIELD_W-1:0] o_field_y,
    output logic signed [afa_pkg::FIELD_W-1:0] o_field_z,
    output logic                          o_applied,
    output logic                          o_saturated,
    output logic                          o_pass_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [afa_pkg::DATA_W-1:0]    i_cfg_data
);
    import afa_pkg::*;

    logic [DATA_W-1:0] r_field_scale;
    logic              q_valid;
    t_item             q_item;
    logic              q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_field_scale <= i_cfg_data;
        end
    end

    afa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_site_index  (i_site_index),
        .i_spin_x      (i_spin_x),
        .i_spin_y      (i_spin_y),
        .i_spin_z      (i_spin_z),
        .i_moment_size (i_moment_size),
        .i_axis_x      (i_axis_x),
        .i_axis_y      (i_axis_y),
        .i_axis_z      (i_axis_z),
        .i_strength    (i_strength),
        .i_last        (i_last),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    afa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_scale     (signed'(r_field_scale)),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_site  (o_out_site),
        .o_field_x   (o_field_x),
        .o_field_y   (o_field_y),
        .o_field_z   (o_field_z),
        .o_applied   (o_applied),
        .o_saturated (o_saturated),
        .o_pass_end  (o_pass_end)
    );
endmodule

@@ tb/afa_field_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afa_field_checker
// Watches the entry, result and scale-write channels of the anisotropy field
// accumulator. Predicts each site total from its own copy of the per-site
// field store and the scale, and compares results in order.
// ----------------------------------------------------------------------------
module afa_field_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic [afa_pkg::SITE_W-1:0]         i_site_index,
    input  logic signed [afa_pkg::DATA_W-1:0]  i_spin_x,
    input  logic signed [afa_pkg::DATA_W-1:0]  i_spin_y,
    input  logic signed [afa_pkg::DATA_W-1:0]  i_spin_z,
    input  logic signed [afa_pkg::DATA_W-1:0]  i_moment_size,
    input  logic signed [afa_pkg::AXIS_W-1:0]  i_axis_x,
    input  logic signed [afa_pkg::AXIS_W-1:0]  i_axis_y,
    input  logic signed [afa_pkg::AXIS_W-1:0]  i_axis_z,
    input  logic signed [afa_pkg::DATA_W-1:0]  i_strength,
    input  logic                               i_last,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic [afa_pkg::SITE_W-1:0]         o_out_site,
    input  logic signed [afa_pkg::FIELD_W-1:0] o_field_x,
    input  logic signed [afa_pkg::FIELD_W-1:0] o_field_y,
    input  logic signed [afa_pkg::FIELD_W-1:0] o_field_z,
    input  logic                               o_applied,
    input  logic                               o_saturated,
    input  logic                               o_pass_end,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [afa_pkg::DATA_W-1:0]         i_cfg_data,
    output int                                 n_fail,
    output int                                 n_pending,
    output int                                 n_results,
    output int                                 n_clipped
);
    import afa_pkg::*;

    typedef struct packed {
        logic [SITE_W-1:0]         site;
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
        logic signed [FIELD_W-1:0] fz;
        logic                      applied;
        logic                      clipped;
        logic                      pass_end;
    } t_site_total;

    localparam longint FIELD_MAX = (64'sd1 <<< (FIELD_W - 1)) - 1;
    localparam longint FIELD_MIN = -(64'sd1 <<< (FIELD_W - 1));

    logic signed [FIELD_W-1:0] field_store [3][SITE_COUNT];
    bit                        pass_fresh;
    logic signed [DATA_W-1:0]  field_scale;
    t_site_total               totals_due[$];

    // round to nearest, ties toward +infinity
    function automatic longint round_shift(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic t_site_total predict_total();
        t_site_total r;
        longint      dot, k, v, p, c, acc, ax[3];
        logic [63:0] ka, da, den;
        logic [127:0] num, q;
        bit          neg;
        r = '0;
        r.site     = i_site_index;
        r.pass_end = i_last;
        if (pass_fresh) begin
            foreach (field_store[a, s]) field_store[a][s] = '0;
        end
        pass_fresh = i_last;
        if (i_moment_size > 0) begin
            ax[0] = i_axis_x;
            ax[1] = i_axis_y;
            ax[2] = i_axis_z;
            k   = i_strength;
            dot = longint'(i_spin_x) * ax[0] + longint'(i_spin_y) * ax[1]
                + longint'(i_spin_z) * ax[2];
            neg = (k < 0) != (dot < 0);
            ka  = (k < 0) ? -k : k;
            da  = (dot < 0) ? -dot : dot;
            den = longint'(i_moment_size) * longint'(i_moment_size);
            num = (128'(ka) * 128'(da)) << 2;
            q   = num / {64'd0, den};
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    q = 128'h8000_0000;
                    r.clipped = 1'b1;
                end
                v = -longint'(q[63:0]);
            end else begin
                if (q > 128'h7FFF_FFFF) begin
                    q = 128'h7FFF_FFFF;
                    r.clipped = 1'b1;
                end
                v = longint'(q[63:0]);
            end
            p = round_shift(v * longint'(field_scale), 16);
            for (int a = 0; a < 3; a++) begin
                c   = round_shift(p * ax[a], 15);
                acc = longint'(field_store[a][i_site_index]) + c;
                if (acc > FIELD_MAX) begin
                    acc = FIELD_MAX;
                    r.clipped = 1'b1;
                end else if (acc < FIELD_MIN) begin
                    acc = FIELD_MIN;
                    r.clipped = 1'b1;
                end
                field_store[a][i_site_index] = acc[FIELD_W-1:0];
            end
            r.applied = 1'b1;
        end
        r.fx = field_store[0][i_site_index];
        r.fy = field_store[1][i_site_index];
        r.fz = field_store[2][i_site_index];
        return r;
    endfunction

    task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_fail++;
        end
    endtask

    initial begin
        n_fail    = 0;
        n_results = 0;
        n_clipped = 0;
    end

    always @(posedge i_clk) begin
        t_site_total want;
        if (!i_rst_n) begin
            pass_fresh  = 1'b1;
            field_scale = SCALE_RESET;
            totals_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) field_scale = i_cfg_data;
            // compare before queueing: a result never belongs to this edge's entry
            if (o_valid && !i_stall) begin
                n_results++;
                if (totals_due.size() == 0) begin
                    $display("%0t: unexpected result for site %h", $time, o_out_site);
                    n_fail++;
                end else begin
                    want = totals_due.pop_front();
                    report_field("out_site", 48'(want.site), 48'(o_out_site));
                    report_field("field_x", want.fx, o_field_x);
                    report_field("field_y", want.fy, o_field_y);
                    report_field("field_z", want.fz, o_field_z);
                    report_field("applied", 48'(want.applied), 48'(o_applied));
                    report_field("saturated", 48'(want.clipped), 48'(o_saturated));
                    report_field("pass_end", 48'(want.pass_end), 48'(o_pass_end));
                    if (want.clipped) n_clipped++;
                end
            end
            if (i_valid && !o_stall) totals_due.push_back(predict_total());
        end
        n_pending <= totals_due.size();
    end

endmodule

@@ tb/tb_anisotropy_field_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anisotropy_field_accumulator_top
// Drives anisotropy entries through the accumulator under random gaps and
// back-pressure, over several field scales, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_anisotropy_field_accumulator_top;
    import afa_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam longint RUN_LIMIT = 64'd1_000_000 * CLK_PERIOD;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [SITE_W-1:0]           i_site_index;
    logic signed [DATA_W-1:0]    i_spin_x;
    logic signed [DATA_W-1:0]    i_spin_y;
    logic signed [DATA_W-1:0]    i_spin_z;
    logic signed [DATA_W-1:0]    i_moment_size;
    logic signed [AXIS_W-1:0]    i_axis_x;
    logic signed [AXIS_W-1:0]    i_axis_y;
    logic signed [AXIS_W-1:0]    i_axis_z;
    logic signed [DATA_W-1:0]    i_strength;
    logic                        i_last;
    logic                        o_valid;
    logic                        i_stall;
    logic [SITE_W-1:0]           o_out_site;
    logic signed [FIELD_W-1:0]   o_field_x;
    logic signed [FIELD_W-1:0]   o_field_y;
    logic signed [FIELD_W-1:0]   o_field_z;
    logic                        o_applied;
    logic                        o_saturated;
    logic                        o_pass_end;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [DATA_W-1:0]           i_cfg_data;

    int n_fail, n_pending, n_results, n_clipped;
    int n_sent;
    int n_scales;

    anisotropy_field_accumulator_top u_dut (.*);
    afa_field_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout after %0d results", n_results);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: long hold-off early on, then a stretch with no stall at all
    initial begin
        int cyc;
        cyc = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= 3000 && cyc < 3600) i_stall = 1'b1;
            else if (cyc >= 20000 && cyc < 40000) i_stall = 1'b0;
            else i_stall = ($urandom_range(0, 99) < 24);
        end
    end

    function automatic int rand_span(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic send_entry(input logic [SITE_W-1:0] site,
                              input logic [DATA_W-1:0] sx, sy, sz, mom,
                              input logic [AXIS_W-1:0] ax, ay, az,
                              input logic [DATA_W-1:0] k, input logic last);
        int gap;
        gap = 0;
        if (!(n_sent >= 400 && n_sent < 650) && $urandom_range(0, 99) < 24)
            gap = $urandom_range(1, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_site_index  = site;
        i_spin_x      = sx;
        i_spin_y      = sy;
        i_spin_z      = sz;
        i_moment_size = mom;
        i_axis_x      = ax;
        i_axis_y      = ay;
        i_axis_z      = az;
        i_strength    = k;
        i_last        = last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_random();
        int                 pick;
        logic [SITE_W-1:0]  site;
        logic [DATA_W-1:0]  sx, sy, sz, mom, k;
        logic [AXIS_W-1:0]  ax, ay, az;
        pick = $urandom_range(0, 99);
        site = ($urandom_range(0, 4) != 0) ? SITE_W'($urandom_range(0, 15))
                                           : SITE_W'($urandom);
        if (pick < 85 && pick >= 60) begin
            // raw noise over every bit
            sx = $urandom; sy = $urandom; sz = $urandom; mom = $urandom; k = $urandom;
            ax = AXIS_W'($urandom); ay = AXIS_W'($urandom); az = AXIS_W'($urandom);
        end else begin
            sx  = rand_span(1 << 17);
            sy  = rand_span(1 << 17);
            sz  = rand_span(1 << 17);
            ax  = AXIS_W'(rand_span(32767));
            ay  = AXIS_W'(rand_span(32767));
            az  = AXIS_W'(rand_span(32767));
            k   = rand_span(1 << 18);
            mom = $urandom_range(1 << 14, 1 << 18);
            if (pick >= 85) begin
                case ($urandom_range(0, 2))
                    0: mom = '0;
                    1: mom = 32'h8000_0000;
                    default: mom = -$urandom_range(1, 1 << 20);
                endcase
            end
        end
        send_entry(site, sx, sy, sz, mom, ax, ay, az, k, $urandom_range(0, 15) == 0);
    endtask

    task automatic set_scale(input logic [DATA_W-1:0] value);
        // deassert valid after the last entry before waiting for the block to drain
        @(negedge i_clk);
        i_valid = 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        n_scales++;
    endtask

    initial begin
        logic [DATA_W-1:0] sc;
        n_sent        = 0;
        n_scales      = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_site_index  = '0;
        i_spin_x      = '0;
        i_spin_y      = '0;
        i_spin_z      = '0;
        i_moment_size = '0;
        i_axis_x      = '0;
        i_axis_y      = '0;
        i_axis_z      = '0;
        i_strength    = '0;
        i_last        = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unit scale: plain, clipped v, skipped moments, zero axis, pass ends
        send_entry(0, 32'h1_0000, 0, 0, 32'h1_0000, 16'h7FFF, 0, 0, 32'h1_0000, 0);
        send_entry(0, 32'h1_0000, 0, 0, 32'h1_0000, 16'h7FFF, 0, 0, 32'h1_0000, 0);
        send_entry(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                   16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 0);
        send_entry(4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                   16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 0);
        send_entry(1, 32'h1_0000, 0, 0, 0, 16'h7FFF, 0, 0, 32'h1_0000, 0);
        send_entry(0, 32'h1_0000, 0, 0, 32'h8000_0000, 16'h7FFF, 0, 0, 32'h1_0000, 0);
        send_entry(2, 32'h1234_5678, 32'h1_0000, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0);
        send_entry(3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 0);
        send_entry(0, 0, 32'h1_0000, 0, 32'h1_0000, 0, 16'h7FFF, 0, 32'h1_0000, 1);
        send_entry(0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 16'h7FFF, 32'h1_0000, 1);
        send_entry(0, 32'h1_0000, 0, 0, 32'h1_0000, 16'h7FFF, 0, 0, 32'h1_0000, 0);

        // largest scale: drive one site into both store limits
        set_scale(32'h7FFF_FFFF);
        repeat (4)
            send_entry(5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                       16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 0);
        for (int i = 0; i < 6; i++)
            send_entry(5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                       16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, i == 5);
        repeat (200) send_random();

        set_scale(32'h8000_0000);
        repeat (200) send_random();
        set_scale(32'h0000_0000);
        repeat (150) send_random();
        repeat (3) begin
            sc = $urandom_range(1 << 12, 1 << 20);
            if ($urandom_range(0, 1)) sc = -sc;
            set_scale(sc);
            repeat (220) send_random();
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("%0d entries sent, %0d results checked over %0d scale writes",
                 n_sent, n_results, n_scales);
        $display("%0d results carried a clip", n_clipped);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
